[src/apq_pkg.sv]
// ----------------------------------------------------------------------------
// apq_pkg
// shared types and constants of the array priority queue
// ----------------------------------------------------------------------------
package apq_pkg;

	localparam int DEPTH  = 8;
	localparam int IDX_W  = $clog2(DEPTH);
	localparam int CNT_W  = $clog2(DEPTH + 1);
	localparam int DATA_W = 32;
	localparam int OCC_W  = 4;
	localparam int REQ_W  = 2;
	localparam int ST_W   = 2;

	localparam logic [REQ_W-1:0] REQ_ENQUEUE = 2'd0;
	localparam logic [REQ_W-1:0] REQ_DEQUEUE = 2'd1;
	localparam logic [REQ_W-1:0] REQ_PEEK    = 2'd2;

	localparam logic [ST_W-1:0] ST_OK       = 2'd0;
	localparam logic [ST_W-1:0] ST_OVERFLOW = 2'd1;
	localparam logic [ST_W-1:0] ST_EMPTY    = 2'd2;

	typedef struct packed {
		logic signed [DATA_W-1:0] value;
		logic signed [DATA_W-1:0] prio;
	} entry_t;

	typedef struct packed {
		logic             vld;
		logic             first;
		logic [IDX_W-1:0] idx;
	} cmp_ctl_t;

endpackage

[src/apq_store.sv]
// ----------------------------------------------------------------------------
// apq_store
// entry memory, one write port and one registered read port
// ----------------------------------------------------------------------------
module apq_store (
	input  logic                  clk,
	input  logic                  we,
	input  logic [apq_pkg::IDX_W-1:0] waddr,
	input  apq_pkg::entry_t       wdata,
	input  logic [apq_pkg::IDX_W-1:0] raddr,
	output apq_pkg::entry_t       rdata
);
	import apq_pkg::*;

	entry_t mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		rdata <= mem_q[raddr];
	end

endmodule

[src/apq_cmp.sv]
// ----------------------------------------------------------------------------
// apq_cmp
// shared priority compare unit, keeps the best entry seen during a scan
// ----------------------------------------------------------------------------
module apq_cmp (
	input  logic                      clk,
	input  apq_pkg::cmp_ctl_t         ctl,
	input  apq_pkg::entry_t           cand,
	output apq_pkg::entry_t           best,
	output logic [apq_pkg::IDX_W-1:0] best_idx
);
	import apq_pkg::*;

	entry_t           best_q;
	logic [IDX_W-1:0] best_idx_q;
	logic             take;

	// strict greater keeps the earliest entry on a tie
	assign take = ctl.vld && (ctl.first || (cand.prio > best_q.prio));

	always_ff @(posedge clk) begin
		if (take) begin
			best_q     <= cand;
			best_idx_q <= ctl.idx;
		end
	end

	assign best     = best_q;
	assign best_idx = best_idx_q;

endmodule

[src/array_priority_queue_unit.sv]
// ----------------------------------------------------------------------------
// array_priority_queue_unit
// unsorted array priority queue with a sequenced scan and compaction
// ----------------------------------------------------------------------------
// enqueue and unused codes: EXEC, then DONE posts the result
// peek: the scan reads one entry a cycle through the store port, then SCAN_WAIT and DONE
// dequeue: the peek scan, then PICK and a compaction that moves the entries above the served one down
// one request at a time; a new request is taken while the result waits
// arst_n clears the sequencer and the count; entry contents are not cleared
// ----------------------------------------------------------------------------
module array_priority_queue_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [63:0] s_tdata,  // in_value, in_priority
	input  logic [1:0]  s_tuser,  // req_type
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [71:0] m_tdata,  // out_value, out_priority, occupancy, zero pad
	output logic [1:0]  m_tuser   // status
);
	import apq_pkg::*;

	typedef enum logic [6:0] {
		S_IDLE      = 7'b0000001,
		S_EXEC      = 7'b0000010,
		S_SCAN      = 7'b0000100,
		S_SCAN_WAIT = 7'b0001000,
		S_PICK      = 7'b0010000,
		S_SHIFT     = 7'b0100000,
		S_DONE      = 7'b1000000
	} state_t;

	state_t           state_q;
	logic [REQ_W-1:0] req_q;
	entry_t           in_q;
	logic [CNT_W-1:0] count_q;
	logic [CNT_W-1:0] i_q;
	logic [CNT_W-1:0] j_q;
	logic [CNT_W-1:0] j_nxt;
	logic [ST_W-1:0]  res_status_q;
	logic             res_hit_q;

	logic             rd_valid_s1;
	logic [IDX_W-1:0] rd_idx_s1;
	logic             wr_pend_s1;
	logic [IDX_W-1:0] wr_idx_s1;

	logic             mem_we;
	logic [IDX_W-1:0] mem_waddr;
	entry_t           mem_wdata;
	logic [IDX_W-1:0] mem_raddr;
	entry_t           mem_rdata;

	cmp_ctl_t         cmp_ctl;
	entry_t           best;
	logic [IDX_W-1:0] best_idx;

	logic             out_free;
	logic             deq_hit;
	logic [CNT_W-1:0] count_out;

	entry_t           out_entry_q;
	logic [ST_W-1:0]  out_status_q;
	logic [OCC_W-1:0] out_occ_q;
	logic             m_valid_q;

	assign s_tready  = (state_q == S_IDLE);
	assign j_nxt     = j_q + CNT_W'(1);
	assign out_free  = !m_valid_q || m_tready;
	assign deq_hit   = res_hit_q && (req_q == REQ_DEQUEUE);
	assign count_out = deq_hit ? (count_q - CNT_W'(1)) : count_q;

	always_comb begin
		mem_raddr = '0;
		unique case (state_q)
			S_SCAN:  mem_raddr = i_q[IDX_W-1:0];
			S_SHIFT: mem_raddr = j_nxt[IDX_W-1:0];
			default: mem_raddr = '0;
		endcase
	end

	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = '0;
		mem_wdata = mem_rdata;
		if (wr_pend_s1) begin
			mem_we    = 1'b1;
			mem_waddr = wr_idx_s1;
			mem_wdata = mem_rdata;
		end else if (state_q == S_EXEC && req_q == REQ_ENQUEUE
				&& count_q < CNT_W'(DEPTH)) begin
			mem_we    = 1'b1;
			mem_waddr = count_q[IDX_W-1:0];
			mem_wdata = in_q;
		end
	end

	assign cmp_ctl.vld   = rd_valid_s1;
	assign cmp_ctl.first = (rd_idx_s1 == '0);
	assign cmp_ctl.idx   = rd_idx_s1;

	apq_store u_store (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	apq_cmp u_cmp (
		.clk      (clk),
		.ctl      (cmp_ctl),
		.cand     (mem_rdata),
		.best     (best),
		.best_idx (best_idx)
	);

	always_ff @(posedge clk) begin
		rd_idx_s1 <= i_q[IDX_W-1:0];
		wr_idx_s1 <= j_q[IDX_W-1:0];
		if (s_tvalid && s_tready) begin
			req_q      <= s_tuser;
			in_q.value <= s_tdata[DATA_W-1:0];
			in_q.prio  <= s_tdata[2*DATA_W-1:DATA_W];
		end
		if (state_q == S_DONE && out_free) begin
			out_entry_q  <= res_hit_q ? best : '0;
			out_status_q <= res_status_q;
			out_occ_q    <= OCC_W'(count_out);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			count_q      <= '0;
			i_q          <= '0;
			j_q          <= '0;
			res_status_q <= ST_OK;
			res_hit_q    <= 1'b0;
			rd_valid_s1  <= 1'b0;
			wr_pend_s1   <= 1'b0;
			m_valid_q    <= 1'b0;
		end else begin
			rd_valid_s1 <= (state_q == S_SCAN);
			wr_pend_s1  <= (state_q == S_SHIFT) && (j_nxt < count_q);
			if (state_q == S_DONE && out_free) begin
				m_valid_q <= 1'b1;
			end else if (m_tready) begin
				m_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (s_tvalid) begin
						state_q <= S_EXEC;
					end
				end
				S_EXEC: begin
					unique case (req_q) inside
						REQ_ENQUEUE: begin
							res_hit_q <= 1'b0;
							state_q   <= S_DONE;
							if (count_q == CNT_W'(DEPTH)) begin
								res_status_q <= ST_OVERFLOW;
							end else begin
								res_status_q <= ST_OK;
								count_q      <= count_q + CNT_W'(1);
							end
						end
						REQ_DEQUEUE, REQ_PEEK: begin
							if (count_q == '0) begin
								res_status_q <= ST_EMPTY;
								res_hit_q    <= 1'b0;
								state_q      <= S_DONE;
							end else begin
								res_status_q <= ST_OK;
								res_hit_q    <= 1'b1;
								i_q          <= '0;
								state_q      <= S_SCAN;
							end
						end
						default: begin
							res_status_q <= ST_OK;
							res_hit_q    <= 1'b0;
							state_q      <= S_DONE;
						end
					endcase
				end
				S_SCAN: begin
					i_q <= i_q + CNT_W'(1);
					if (i_q == count_q - CNT_W'(1)) begin
						state_q <= S_SCAN_WAIT;
					end
				end
				S_SCAN_WAIT: begin
					state_q <= (req_q == REQ_DEQUEUE) ? S_PICK : S_DONE;
				end
				S_PICK: begin
					j_q     <= CNT_W'(best_idx);
					state_q <= S_SHIFT;
				end
				S_SHIFT: begin
					if (j_nxt < count_q) begin
						j_q <= j_nxt;
					end else begin
						state_q <= S_DONE;
					end
				end
				S_DONE: begin
					if (out_free) begin
						count_q <= count_out;
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = {4'b0000, out_occ_q, out_entry_q.prio, out_entry_q.value};
	assign m_tuser  = out_status_q;

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(DEPTH))
		else $error("entry count above depth");

	a_scan_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SCAN) |-> (count_q != '0))
		else $error("scan on an empty store");

	a_shift_write: assert property (@(posedge clk) disable iff (!arst_n)
		wr_pend_s1 |-> (state_q == S_SHIFT || state_q == S_DONE))
		else $error("compaction write outside dequeue");

	a_result_once: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DONE && out_free) |=> (m_valid_q && state_q == S_IDLE))
		else $error("result not posted");

endmodule
